// ===== rtl/mbce_pkg.sv =====
// ----------------------------------------------------------------------------
// mbce_pkg: shared types and constants for the bitmap color expander
// Holds the panel command codes, request codes, queue depth and the layout
// of one queued job passed from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package mbce_pkg;

    // Largest window side in pixels; wider requests saturate to it.
    localparam int MAX_SIDE_DEFAULT = 2048;

    // Number of jobs held between the front end and the back end.
    localparam int QUEUE_DEPTH = 4;

    // Request type codes.
    localparam logic REQ_BEGIN  = 1'b0;
    localparam logic REQ_BITMAP = 1'b1;

    // Panel command codes.
    localparam logic [15:0] CMD_COL = 16'h002A;
    localparam logic [15:0] CMD_ROW = 16'h002B;
    localparam logic [15:0] CMD_MEM = 16'h002C;

    // Pixels carried by one bitmap byte.
    localparam logic [3:0] PIX_PER_BYTE = 4'd8;

    // One job for the back end: either a window setup or a run of pixels.
    typedef struct packed {
        logic        is_begin;
        logic [10:0] x_start;
        logic [15:0] x_end;
        logic [10:0] y_start;
        logic [15:0] y_end;
        logic [15:0] fore;
        logic [15:0] back;
        logic [7:0]  bits;
        logic [3:0]  count;
    } job_t;

endpackage

`default_nettype wire

// ===== rtl/mbce_front.sv =====
// ----------------------------------------------------------------------------
// mbce_front: request intake and classification
// Accepts begin and bitmap items, saturates the window size, finds the window
// ends, tracks pixels owed, queues a job per item bar bytes with none owed.
// ----------------------------------------------------------------------------
`default_nettype none

module mbce_front #(
    parameter int MAX_SIDE = mbce_pkg::MAX_SIDE_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic         req_type,
    input  wire logic [10:0]  x_start,
    input  wire logic [10:0]  y_start,
    input  wire logic [11:0]  glyph_width,
    input  wire logic [11:0]  glyph_height,
    input  wire logic [15:0]  fore_color,
    input  wire logic [15:0]  back_color,
    input  wire logic [7:0]   bitmap_byte,
    output logic              q_push,
    output mbce_pkg::job_t    q_job,
    input  wire logic         q_full
);
    import mbce_pkg::*;

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CNT_W  = 2 * SIDE_W;
    localparam logic [12:0] SIDE_CAP = 13'(MAX_SIDE);
    localparam logic [CNT_W-1:0] MAX_PIX = CNT_W'(MAX_SIDE * MAX_SIDE);

    logic [CNT_W-1:0]  pixels_left_reg;
    logic [CNT_W-1:0]  pixels_left_next;
    logic [15:0]       fore_reg;
    logic [15:0]       fore_next;
    logic [15:0]       back_reg;
    logic [15:0]       back_next;
    logic              accept;
    logic [SIDE_W-1:0] width_sat;
    logic [SIDE_W-1:0] height_sat;
    logic [3:0]        run_len;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Saturate both sides to the largest window.
    assign width_sat  = ({1'b0, glyph_width} > SIDE_CAP) ? SIDE_W'(MAX_SIDE)
                                                        : SIDE_W'(glyph_width);
    assign height_sat = ({1'b0, glyph_height} > SIDE_CAP) ? SIDE_W'(MAX_SIDE)
                                                         : SIDE_W'(glyph_height);

    // Pixels this byte can emit: at most eight, fewer at the end of a glyph.
    assign run_len = (pixels_left_reg < CNT_W'(PIX_PER_BYTE)) ? pixels_left_reg[3:0]
                                                             : PIX_PER_BYTE;

    // Build the job and the next pixel count.
    always_comb
    begin
        pixels_left_next = pixels_left_reg;
        fore_next        = fore_reg;
        back_next        = back_reg;
        q_push           = 1'b0;
        q_job            = '0;
        if (accept)
        begin
            if (req_type == REQ_BEGIN)
            begin
                pixels_left_next = CNT_W'(width_sat) * CNT_W'(height_sat);
                fore_next        = fore_color;
                back_next        = back_color;
                q_push           = 1'b1;
                q_job.is_begin   = 1'b1;
                q_job.x_start    = x_start;
                q_job.x_end      = 16'(x_start) + 16'(width_sat) - 16'd1;
                q_job.y_start    = y_start;
                q_job.y_end      = 16'(y_start) + 16'(height_sat) - 16'd1;
            end
            else if (pixels_left_reg != '0)
            begin
                pixels_left_next = pixels_left_reg - CNT_W'(run_len);
                q_push           = 1'b1;
                q_job.fore       = fore_reg;
                q_job.back       = back_reg;
                q_job.bits       = bitmap_byte;
                q_job.count      = run_len;
            end
        end
    end

    // Glyph state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixels_left_reg <= '0;
            fore_reg        <= '0;
            back_reg        <= '0;
        end
        else
        begin
            pixels_left_reg <= pixels_left_next;
            fore_reg        <= fore_next;
            back_reg        <= back_next;
        end
    end

    // The pixel count never exceeds a full window.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixels_left_reg <= MAX_PIX)
        else $error("pixel count exceeds a full window");

    // A bitmap job is only queued while pixels are owed, with a legal length.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push && !q_job.is_begin |-> q_job.count != 4'd0 && q_job.count <= PIX_PER_BYTE)
        else $error("bitmap job with an illegal pixel count");

endmodule

`default_nettype wire

// ===== rtl/mbce_queue.sv =====
// ----------------------------------------------------------------------------
// mbce_queue: job queue between front end and back end
// A small first-in first-out store of jobs, so that intake and bus output
// stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module mbce_queue #(
    parameter int DEPTH = mbce_pkg::QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  mbce_pkg::job_t    wr_job,
    output logic              q_full,
    input  wire logic         rd_en,
    output mbce_pkg::job_t    rd_job,
    output logic              q_empty
);
    import mbce_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (fill_reg == CNT_FULL);
    assign q_empty = (fill_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_job  = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + CNT_ONE;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    // The fill count never goes beyond the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_FULL)
        else $error("queue fill count beyond depth");

endmodule

`default_nettype wire

// ===== rtl/mbce_back.sv =====
// ----------------------------------------------------------------------------
// mbce_back: bus word sequencer
// Walks the job at the head of the queue one bus word per cycle while the
// output register is free or popped; the consumer drains it with pop.
// ----------------------------------------------------------------------------
`default_nettype none

module mbce_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  mbce_pkg::job_t    head_job,
    input  wire logic         q_empty,
    output logic              q_pop,
    output logic              empty,
    input  wire logic         pop,
    output logic              is_command,
    output logic [15:0]       bus_word,
    output logic              last_of_run
);
    import mbce_pkg::*;

    // Steps of the window sequence; pixel runs use steps 0 to 7.
    localparam logic [3:0] STEP_COL_CMD = 4'd0;
    localparam logic [3:0] STEP_XS_HI   = 4'd1;
    localparam logic [3:0] STEP_XS_LO   = 4'd2;
    localparam logic [3:0] STEP_XE_HI   = 4'd3;
    localparam logic [3:0] STEP_XE_LO   = 4'd4;
    localparam logic [3:0] STEP_ROW_CMD = 4'd5;
    localparam logic [3:0] STEP_YS_HI   = 4'd6;
    localparam logic [3:0] STEP_YS_LO   = 4'd7;
    localparam logic [3:0] STEP_YE_HI   = 4'd8;
    localparam logic [3:0] STEP_YE_LO   = 4'd9;
    localparam logic [3:0] STEP_MEM_CMD = 4'd10;

    logic [3:0]  step_reg;
    logic [3:0]  step_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        cmd_reg;
    logic [15:0] word_reg;
    logic        last_reg;
    logic        out_free;
    logic        fire;
    logic        word_cmd;
    logic [15:0] word_val;
    logic        word_last;
    logic [15:0] xs_wide;
    logic [15:0] ys_wide;

    assign out_free = !out_valid_reg || pop;
    assign fire     = !q_empty && out_free;
    assign xs_wide  = 16'(head_job.x_start);
    assign ys_wide  = 16'(head_job.y_start);

    // Select the word for the current step of the head job.
    always_comb
    begin
        word_cmd  = 1'b0;
        word_val  = '0;
        word_last = 1'b0;
        if (head_job.is_begin)
        begin
            case (step_reg)
                STEP_COL_CMD:
                begin
                    word_cmd = 1'b1;
                    word_val = CMD_COL;
                end
                STEP_XS_HI: word_val = {8'd0, xs_wide[15:8]};
                STEP_XS_LO: word_val = {8'd0, xs_wide[7:0]};
                STEP_XE_HI: word_val = {8'd0, head_job.x_end[15:8]};
                STEP_XE_LO: word_val = {8'd0, head_job.x_end[7:0]};
                STEP_ROW_CMD:
                begin
                    word_cmd = 1'b1;
                    word_val = CMD_ROW;
                end
                STEP_YS_HI: word_val = {8'd0, ys_wide[15:8]};
                STEP_YS_LO: word_val = {8'd0, ys_wide[7:0]};
                STEP_YE_HI: word_val = {8'd0, head_job.y_end[15:8]};
                STEP_YE_LO: word_val = {8'd0, head_job.y_end[7:0]};
                STEP_MEM_CMD:
                begin
                    word_cmd  = 1'b1;
                    word_val  = CMD_MEM;
                    word_last = 1'b1;
                end
                default:
                begin
                    word_cmd  = 1'b1;
                    word_val  = CMD_MEM;
                    word_last = 1'b1;
                end
            endcase
        end
        else
        begin
            // Bits go out most significant first.
            word_val  = head_job.bits[~step_reg[2:0]] ? head_job.fore : head_job.back;
            word_last = (step_reg == head_job.count - 4'd1);
        end
    end

    // Step through the job and retire it after its last word.
    always_comb
    begin
        step_next      = step_reg;
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg && !pop;
        if (fire)
        begin
            out_valid_next = 1'b1;
            if (word_last)
            begin
                step_next = '0;
                q_pop     = 1'b1;
            end
            else
            begin
                step_next = step_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            cmd_reg  <= word_cmd;
            word_reg <= word_val;
            last_reg <= word_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign is_command  = cmd_reg;
    assign bus_word    = word_reg;
    assign last_of_run = last_reg;

    // The step counter stays within the window sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_MEM_CMD)
        else $error("sequencer step out of range");

    // A pixel run never goes past eight words.
    assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty && !head_job.is_begin |-> step_reg < PIX_PER_BYTE)
        else $error("pixel run step beyond one byte");

    // A word emitted mid-job is followed by the next step of the same job.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !word_last |=> step_reg == $past(step_reg) + 4'd1)
        else $error("sequencer skipped a step");

endmodule

`default_nettype wire

// ===== rtl/mono_bitmap_color_expand_top.sv =====
// An accepted item is first written into the job queue; its words then reach the result ports via the output register.
// Throughput: one bus word per cycle while the consumer keeps the output register drained; a begin item
// makes 11 words, a bitmap byte one word per pixel it emits (up to 8), a byte with no glyph pending none.
// The back-end sequencer and its one-word output register set that rate.
// Reset: rst_n clears the queue, the output register and the glyph state at once.
// ----------------------------------------------------------------------------
// mono_bitmap_color_expand_top: monochrome bitmap color expander
// Turns glyph requests and bitmap bytes into panel command and pixel words.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_bitmap_color_expand_top #(
    parameter int MAX_SIDE = mbce_pkg::MAX_SIDE_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic         req_type,
    input  wire logic [10:0]  x_start,
    input  wire logic [10:0]  y_start,
    input  wire logic [11:0]  glyph_width,
    input  wire logic [11:0]  glyph_height,
    input  wire logic [15:0]  fore_color,
    input  wire logic [15:0]  back_color,
    input  wire logic [7:0]   bitmap_byte,
    output logic              empty,
    input  wire logic         pop,
    output logic              is_command,
    output logic [15:0]       bus_word,
    output logic              last_of_run
);
    import mbce_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    job_t q_job;
    job_t head_job;

    // Intake and classification.
    mbce_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .x_start      (x_start),
        .y_start      (y_start),
        .glyph_width  (glyph_width),
        .glyph_height (glyph_height),
        .fore_color   (fore_color),
        .back_color   (back_color),
        .bitmap_byte  (bitmap_byte),
        .q_push       (q_push),
        .q_job        (q_job),
        .q_full       (q_full)
    );

    // Job queue.
    mbce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_job  (q_job),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_job  (head_job),
        .q_empty (q_empty)
    );

    // Bus word sequencer.
    mbce_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .is_command  (is_command),
        .bus_word    (bus_word),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

// ===== tb/mono_bitmap_color_expand_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mono_bitmap_color_expand_top_test: self-checking bench for the glyph expander
// Sends glyph begin items and bitmap bytes through the push side. A scoreboard
// class predicts every panel bus write. Each popped write is compared with
// the oldest prediction. Both sides idle at random, and the receiver holds off
// once for a long stretch so that the input side fills and stalls.
// ----------------------------------------------------------------------------

import mbce_pkg::*;

// One predicted write on the panel bus.
typedef struct packed {
    logic        is_cmd;
    logic [15:0] word;
    logic        last;
} bus_write_t;

// Tracks the glyph state and holds the panel writes still owed by the block.
class glyph_scoreboard;
    bus_write_t  owed[$];
    bus_write_t  run[11];
    int          run_len;
    logic [22:0] pix_owed;
    logic [15:0] fore_hold;
    logic [15:0] back_hold;
    int          errors;

    function new();
        pix_owed  = '0;
        fore_hold = '0;
        back_hold = '0;
        errors    = 0;
        run_len   = 0;
    endfunction

    function void add_write(logic cmd, logic [15:0] word);
        run[run_len] = '{is_cmd: cmd, word: word, last: 1'b0};
        run_len++;
    endfunction

    // A window side goes out as a command, then the first and last position,
    // each as a high byte and a low byte.
    function void add_range(logic [15:0] cmd, logic [15:0] first, logic [15:0] span);
        logic [15:0] last_pos;
        last_pos = first + span - 16'd1;
        add_write(1'b1, cmd);
        add_write(1'b0, {8'h00, first[15:8]});
        add_write(1'b0, {8'h00, first[7:0]});
        add_write(1'b0, {8'h00, last_pos[15:8]});
        add_write(1'b0, {8'h00, last_pos[7:0]});
    endfunction

    // Notes an accepted item and queues the writes it causes; returns their number.
    function int note_item(logic kind, logic [10:0] xs, logic [10:0] ys,
                           logic [11:0] w, logic [11:0] h,
                           logic [15:0] fg, logic [15:0] bg, logic [7:0] bits);
        logic [11:0] side_w;
        logic [11:0] side_h;
        run_len = 0;
        if (kind == REQ_BEGIN)
        begin
            // Oversized sides saturate for both the window and the pixel count.
            side_w = (w > MAX_SIDE_DEFAULT) ? 12'(MAX_SIDE_DEFAULT) : w;
            side_h = (h > MAX_SIDE_DEFAULT) ? 12'(MAX_SIDE_DEFAULT) : h;
            fore_hold = fg;
            back_hold = bg;
            pix_owed  = 23'(side_w) * 23'(side_h);
            add_range(CMD_COL, 16'(xs), 16'(side_w));
            add_range(CMD_ROW, 16'(ys), 16'(side_h));
            add_write(1'b1, CMD_MEM);
        end
        else
        begin
            // Bits past the end of the glyph are dropped.
            for (int i = 7; i >= 0 && pix_owed != 0; i--)
            begin
                add_write(1'b0, bits[i] ? fore_hold : back_hold);
                pix_owed--;
            end
        end
        for (int i = 0; i < run_len; i++)
        begin
            run[i].last = (i == run_len - 1);
            owed.push_back(run[i]);
        end
        return run_len;
    endfunction

    // Compares one popped write with the oldest prediction.
    function void check_word(logic cmd, logic [15:0] word, logic last);
        bus_write_t want;
        if (owed.size() == 0)
        begin
            $display("%0t ERROR: unexpected write cmd=%0b word=%h last=%0b",
                     $time, cmd, word, last);
            errors++;
            return;
        end
        want = owed.pop_front();
        if (cmd !== want.is_cmd)
        begin
            $display("%0t ERROR: is_command expected %0b, got %0b", $time, want.is_cmd, cmd);
            errors++;
        end
        if (word !== want.word)
        begin
            $display("%0t ERROR: bus_word expected %h, got %h", $time, want.word, word);
            errors++;
        end
        if (last !== want.last)
        begin
            $display("%0t ERROR: last_of_run expected %0b, got %0b", $time, want.last, last);
            errors++;
        end
    endfunction
endclass

module mono_bitmap_color_expand_top_test;

    localparam int ITEM_GOAL   = 370;
    localparam int CALM_ITEMS  = 50;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 500000;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        push         = 1'b0;
    logic        req_type     = REQ_BEGIN;
    logic [10:0] x_start      = '0;
    logic [10:0] y_start      = '0;
    logic [11:0] glyph_width  = '0;
    logic [11:0] glyph_height = '0;
    logic [15:0] fore_color   = '0;
    logic [15:0] back_color   = '0;
    logic [7:0]  bitmap_byte  = '0;
    logic        pop          = 1'b0;
    logic        full;
    logic        empty;
    logic        is_command;
    logic [15:0] bus_word;
    logic        last_of_run;

    glyph_scoreboard sb = new();
    int   worked_items  = 0;
    int   cycle_count   = 0;
    bit   calm          = 1'b0;
    bit   hold_due      = 1'b0;
    bit   hold_done     = 1'b0;

    mono_bitmap_color_expand_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .x_start      (x_start),
        .y_start      (y_start),
        .glyph_width  (glyph_width),
        .glyph_height (glyph_height),
        .fore_color   (fore_color),
        .back_color   (back_color),
        .bitmap_byte  (bitmap_byte),
        .empty        (empty),
        .pop          (pop),
        .is_command   (is_command),
        .bus_word     (bus_word),
        .last_of_run  (last_of_run)
    );

    // 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("mono_bitmap_color_expand_top test failed");
            $finish;
        end
    end

    // Both handshakes are sampled at the clock edge, before any drive updates.
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            if (sb.note_item(req_type, x_start, y_start, glyph_width, glyph_height,
                             fore_color, back_color, bitmap_byte) > 0)
                worked_items++;
        end
        if (rst_n && pop && !empty)
            sb.check_word(is_command, bus_word, last_of_run);
    end

    // Random gap before an item, only in sequences that idle at all.
    function automatic int pick_gap(bit gappy);
        if (gappy && !calm && $urandom_range(0, 3) == 0)
            return $urandom_range(1, 6);
        return 0;
    endfunction

    // Offers one item after an optional gap and waits until it is taken.
    task automatic send_item(logic kind, logic [10:0] xs, logic [10:0] ys,
                             logic [11:0] w, logic [11:0] h,
                             logic [15:0] fg, logic [15:0] bg, logic [7:0] bits,
                             int gap);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        req_type     <= kind;
        x_start      <= xs;
        y_start      <= ys;
        glyph_width  <= w;
        glyph_height <= h;
        fore_color   <= fg;
        back_color   <= bg;
        bitmap_byte  <= bits;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
    endtask

    // Fields that an item does not use carry random noise.
    task automatic begin_glyph(logic [10:0] xs, logic [10:0] ys, logic [11:0] w,
                               logic [11:0] h, logic [15:0] fg, logic [15:0] bg,
                               int gap);
        send_item(REQ_BEGIN, xs, ys, w, h, fg, bg, 8'($urandom_range(0, 255)), gap);
    endtask

    task automatic send_byte(logic [7:0] bits, int gap);
        send_item(REQ_BITMAP, 11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                  12'($urandom), 12'($urandom), 16'($urandom), 16'($urandom), bits, gap);
    endtask

    // One random glyph: mostly a small well-formed one, sometimes large,
    // cut short, padded with extra bytes, or a lone noise item.
    task automatic random_glyph();
        logic [11:0] w;
        logic [11:0] h;
        int          side_w;
        int          side_h;
        int          nbytes;
        int          roll;
        bit          gappy;
        gappy = ($urandom_range(0, 2) != 0);
        roll  = $urandom_range(0, 99);
        if (roll < 10)
        begin
            send_item(1'($urandom), 11'($urandom), 11'($urandom), 12'($urandom),
                      12'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                      pick_gap(gappy));
            return;
        end
        w = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(1, 12));
        h = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(1, 12));
        side_w = (w > MAX_SIDE_DEFAULT) ? MAX_SIDE_DEFAULT : int'(w);
        side_h = (h > MAX_SIDE_DEFAULT) ? MAX_SIDE_DEFAULT : int'(h);
        nbytes = (side_w * side_h + 7) / 8;
        // Large glyphs are abandoned after a few bytes.
        if (nbytes > 24)
            nbytes = $urandom_range(1, 24);
        roll = $urandom_range(0, 99);
        if (roll < 15)
            nbytes = $urandom_range(0, nbytes);
        else if (roll >= 88)
            nbytes += $urandom_range(1, 2);
        begin_glyph(11'($urandom), 11'($urandom), w, h, 16'($urandom), 16'($urandom),
                    pick_gap(gappy));
        for (int i = 0; i < nbytes; i++)
            send_byte(8'($urandom), pick_gap(gappy));
    endtask

    // Receiver: random pop bursts and stalls, one long hold-off, none at the end.
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!calm && hold_due && !hold_done)
            begin
                hold_done = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Reset, stimulus and end of run.
    initial
    begin
        int drain;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part.
        send_byte(8'hFF, 0);                                      // no glyph pending
        begin_glyph(11'd0, 11'd0, 12'd1, 12'd1, 16'hFFFF, 16'h0000, 0);
        send_byte(8'h80, 0);                                      // one pixel, rest dropped
        send_byte(8'h55, 0);                                      // glyph already done
        begin_glyph(11'h7FF, 11'h7FF, 12'd2048, 12'd2048, 16'h0000, 16'hFFFF, 0);
        send_byte(8'h00, 1);
        send_byte(8'hFF, 0);
        begin_glyph(11'd0, 11'd0, 12'd0, 12'd0, 16'hAAAA, 16'h5555, 0); // end wraps
        send_byte(8'hA5, 0);                                      // zero pixels pending
        begin_glyph(11'd1234, 11'd5, 12'hFFF, 12'd2049, 16'h1234, 16'hABCD, 0);
        send_byte(8'h5A, 0);
        begin_glyph(11'h555, 11'h2AA, 12'd3, 12'd5, 16'hF800, 16'h07E0, 2);
        send_byte(8'hA5, 0);
        send_byte(8'h3C, 0);                                      // last seven pixels
        send_byte(8'hFF, 0);                                      // glyph already done
        begin_glyph(11'd100, 11'd200, 12'd8, 12'd8, 16'h001F, 16'hFFE0, 0);
        send_byte(8'hC3, 0);
        begin_glyph(11'd7, 11'd9, 12'd2, 12'd1, 16'h0F0F, 16'hF0F0, 0); // abandons 8x8
        send_byte(8'h40, 0);
        begin_glyph(11'd10, 11'd0, 12'd0, 12'd10, 16'h7777, 16'h8888, 0);
        send_byte(8'h99, 3);

        // Random part.
        while (worked_items < ITEM_GOAL)
        begin
            if (worked_items >= HOLD_AT)
                hold_due = 1'b1;
            if (worked_items >= ITEM_GOAL - CALM_ITEMS)
                calm = 1'b1;
            random_glyph();
        end
        push <= 1'b0;

        // Drain the remaining writes, then allow for the pipeline latency.
        drain = 0;
        do
        begin
            @(posedge clk);
            drain++;
        end
        while (sb.owed.size() != 0 && drain < 4000);
        repeat (16) @(posedge clk);
        if (sb.owed.size() != 0)
        begin
            $display("%0t ERROR: %0d writes never arrived, next expected word=%h",
                     $time, sb.owed.size(), sb.owed[0].word);
            sb.errors++;
        end

        if (sb.errors == 0)
            $display("mono_bitmap_color_expand_top test passed");
        else
            $display("mono_bitmap_color_expand_top test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mbce_pkg.sv
rtl/mbce_front.sv
rtl/mbce_queue.sv
rtl/mbce_back.sv
rtl/mono_bitmap_color_expand_top.sv
tb/mono_bitmap_color_expand_top_test.sv
